// File: design/capture_frequency_meter_assert.svh
// assertion macros for the capture frequency meter checker
// expects clk and rst in the scope of each use
`ifndef CAPTURE_FREQUENCY_METER_ASSERT_SVH
`define CAPTURE_FREQUENCY_METER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define CFM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define CFM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cfm_pkg.sv
// shared types and constants of the capture frequency meter
// no dependencies
package cfm_pkg;

  localparam int CH_W        = 2;
  localparam int NUM_PORT_CH = 2 ** CH_W;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(DATA_W);
  localparam int CAP_W       = 16;
  localparam int PRESCALE_W  = 17;
  localparam int SKIP_W      = 8;
  localparam int TO_W        = 17;
  localparam int DONE_W      = 9;
  localparam int CFG_IDX_W   = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [TO_W-1:0] TIMEOUT_MAX = {TO_W{1'b1}};

  // request and event codes
  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;
  localparam logic EVT_DONE    = 1'b0;
  localparam logic EVT_TIMEOUT = 1'b1;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_CLOCK = 3'd0,
    REG_PRESCALE    = 3'd1,
    REG_RELOAD      = 3'd2,
    REG_SKIP        = 3'd3,
    REG_TIMEOUT     = 3'd4,
    REG_ENABLE      = 3'd5
  } cfg_reg_t;

  localparam logic [DATA_W-1:0]     RST_TIMER_CLOCK = 32'd64000000;
  localparam logic [PRESCALE_W-1:0] RST_PRESCALE    = 17'd1;
  localparam logic [CAP_W-1:0]      RST_RELOAD      = 16'hFFFF;
  localparam logic [SKIP_W-1:0]     RST_SKIP        = 8'd0;
  localparam logic [CAP_W-1:0]      RST_TIMEOUT     = 16'd10;
  localparam logic [NUM_PORT_CH-1:0] RST_ENABLE     = 4'd0;

  typedef struct packed {
    logic [DATA_W-1:0]      timer_clock_hz;
    logic [PRESCALE_W-1:0]  prescale;
    logic [CAP_W-1:0]       reload_value;
    logic [SKIP_W-1:0]      success_skip;
    logic [CAP_W-1:0]       timeout_limit;
    logic [NUM_PORT_CH-1:0] channel_enable;
  } cfg_t;

  // one classified item that has at least one report to deliver
  typedef struct packed {
    logic [NUM_PORT_CH-1:0] mask;
    logic                   done_rep;
    logic [CH_W-1:0]        done_ch;
    logic [DATA_W-1:0]      lap;
    logic [CAP_W-1:0]       start;
    logic [CAP_W-1:0]       capv;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_CHK,
    BK_DIV_CLK,
    BK_DIV_PER,
    BK_EMIT
  } bk_state_t;

endpackage

// File: design/cfm_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on cfm_pkg
module cfm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cfm_pkg::DATA_W-1:0] dividend,
  input  logic [cfm_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [cfm_pkg::DATA_W-1:0] quotient
);
  import cfm_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted  = {rem, quo[DATA_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(DATA_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: design/cfm_queue.sv
// short job queue between the classifying front and the reporting back
// depends on cfm_pkg
module cfm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfm_pkg::job_t push_job,
  input  logic          pop,
  output cfm_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);
  import cfm_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

// File: design/cfm_front.sv
// front: per-channel capture state, timeout counting and report decisions
// depends on cfm_pkg
module cfm_front #(
  parameter int CHANNELS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfm_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [cfm_pkg::CH_W-1:0]  channel,
  input  logic [cfm_pkg::CAP_W-1:0] capture_value,
  input  logic                      q_full,
  output logic                      push,
  output cfm_pkg::job_t             push_job
);
  import cfm_pkg::*;

  // channels past the addressable ones can never be enabled or hit
  localparam int ACT_CH = (CHANNELS < NUM_PORT_CH) ? CHANNELS : NUM_PORT_CH;

  logic              edge_seen          [ACT_CH];
  logic              edge_seen_next     [ACT_CH];
  logic              waiting_end        [ACT_CH];
  logic              waiting_end_next   [ACT_CH];
  logic [CAP_W-1:0]  start_capture      [ACT_CH];
  logic [CAP_W-1:0]  start_capture_next [ACT_CH];
  logic [DATA_W-1:0] lap_count          [ACT_CH];
  logic [DATA_W-1:0] lap_count_next     [ACT_CH];
  logic [TO_W-1:0]   timeout_count      [ACT_CH];
  logic [TO_W-1:0]   timeout_count_next [ACT_CH];
  logic [DONE_W-1:0] done_count;
  logic [DONE_W-1:0] done_count_next;

  logic       accept;
  logic       any_done;
  logic [DONE_W-1:0] done_inc;
  job_t       job;

  assign accept   = in_valid && !q_full;
  assign in_ready = !q_full;
  assign push_job = job;
  assign push     = accept && (job.mask != '0);

  always_comb begin
    logic hit;
    logic tick;
    logic done_i;
    edge_seen_next     = edge_seen;
    waiting_end_next   = waiting_end;
    start_capture_next = start_capture;
    lap_count_next     = lap_count;
    timeout_count_next = timeout_count;
    done_count_next    = done_count;
    any_done           = 1'b0;
    job                = '0;
    job.capv           = capture_value;
    for (int i = 0; i < ACT_CH; i++) begin
      hit    = accept && (req_type == REQ_CAPTURE) && (channel == CH_W'(i))
               && cfg.channel_enable[i];
      tick   = accept && (req_type == REQ_TICK);
      done_i = 1'b0;
      if (hit) begin
        if (!edge_seen[i]) begin
          edge_seen_next[i] = 1'b1;
        end else if (!waiting_end[i]) begin
          start_capture_next[i] = capture_value;
          waiting_end_next[i]   = 1'b1;
          lap_count_next[i]     = '0;
        end else begin
          waiting_end_next[i] = 1'b0;
          done_i              = 1'b1;
          job.done_ch         = CH_W'(i);
          job.lap             = lap_count[i];
          job.start           = start_capture[i];
        end
      end
      if (tick) begin
        lap_count_next[i] = lap_count[i] + 1'b1;
        if (cfg.channel_enable[i] && (timeout_count[i] != TIMEOUT_MAX)) begin
          timeout_count_next[i] = timeout_count[i] + 1'b1;
        end
      end
      if (accept) begin
        if (done_i) begin
          timeout_count_next[i] = '0;
          any_done              = 1'b1;
        end else if (timeout_count_next[i] > {1'b0, cfg.timeout_limit}) begin
          timeout_count_next[i] = '0;
          waiting_end_next[i]   = 1'b0;
          job.mask[i]           = 1'b1;
        end
      end
    end
    // shared decimation of completed measurements
    done_inc = done_count + 1'b1;
    if (any_done) begin
      if (done_inc > {1'b0, cfg.success_skip}) begin
        done_count_next      = '0;
        job.done_rep         = 1'b1;
        job.mask[job.done_ch] = 1'b1;
      end else begin
        done_count_next = done_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ACT_CH; i++) begin
        edge_seen[i]     <= 1'b0;
        waiting_end[i]   <= 1'b0;
        start_capture[i] <= '0;
        lap_count[i]     <= '0;
        timeout_count[i] <= '0;
      end
      done_count <= '0;
    end else begin
      edge_seen     <= edge_seen_next;
      waiting_end   <= waiting_end_next;
      start_capture <= start_capture_next;
      lap_count     <= lap_count_next;
      timeout_count <= timeout_count_next;
      done_count    <= done_count_next;
    end
  end

endmodule

// File: design/cfm_back.sv
// back: period arithmetic, frequency division and ordered report output
// depends on cfm_pkg and cfm_div
module cfm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  cfm_pkg::cfg_t              cfg,
  input  logic                       q_empty,
  input  cfm_pkg::job_t              q_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cfm_pkg::CH_W-1:0]   out_channel,
  output logic                       event_kind,
  output logic [cfm_pkg::DATA_W-1:0] frequency,
  output logic                       last
);
  import cfm_pkg::*;

  bk_state_t state;
  bk_state_t state_next;

  job_t                   job;
  logic [NUM_PORT_CH-1:0] pend;
  logic [DATA_W-1:0]      product;
  logic [DATA_W-1:0]      period;
  logic [DATA_W-1:0]      freq;

  logic [PRESCALE_W-1:0]       lap_len;
  logic [PRESCALE_W+DATA_W-1:0] mul_full;
  logic                        zero_div;

  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quotient;

  logic                   out_load;
  logic [CH_W-1:0]        pick;
  logic [NUM_PORT_CH-1:0] pick_hot;
  logic [NUM_PORT_CH-1:0] pend_rest;
  logic                   pick_kind;

  assign lap_len  = {1'b0, cfg.reload_value} + 1'b1;
  assign mul_full = lap_len * job.lap;
  assign zero_div = (cfg.prescale == '0) || (period == '0);

  cfm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // lowest pending channel goes first
  always_comb begin
    pick = '0;
    for (int i = NUM_PORT_CH - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick = CH_W'(i);
      end
    end
    pick_hot  = NUM_PORT_CH'(1) << pick;
    pend_rest = pend & ~pick_hot;
    pick_kind = (job.done_rep && (pick == job.done_ch)) ? EVT_DONE : EVT_TIMEOUT;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = q_job.done_rep ? BK_MUL : BK_EMIT;
        end
      end
      BK_MUL:  state_next = BK_ADD;
      BK_ADD:  state_next = BK_CHK;
      BK_CHK:  state_next = zero_div ? BK_EMIT : BK_DIV_CLK;
      BK_DIV_CLK: begin
        if (div_done) begin
          state_next = BK_DIV_PER;
        end
      end
      BK_DIV_PER: begin
        if (div_done) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (pend == '0) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = (state == BK_IDLE) && !q_empty;
    div_start    = ((state == BK_CHK) && !zero_div) || ((state == BK_DIV_CLK) && div_done);
    div_dividend = (state == BK_CHK) ? cfg.timer_clock_hz : div_quotient;
    div_divisor  = (state == BK_CHK) ? DATA_W'(cfg.prescale) : period;
    out_load     = (state == BK_EMIT) && (pend != '0) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        pend <= q_job.mask;
      end else if (out_load) begin
        pend <= pend_rest;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
    if (state == BK_MUL) begin
      product <= mul_full[DATA_W-1:0];
    end
    if (state == BK_ADD) begin
      period <= product + DATA_W'(job.capv) - DATA_W'(job.start);
    end
    if (state == BK_CHK) begin
      freq <= '0;
    end else if ((state == BK_DIV_PER) && div_done) begin
      freq <= div_quotient;
    end
    if (out_load) begin
      out_channel <= pick;
      event_kind  <= pick_kind;
      frequency   <= (pick_kind == EVT_DONE) ? freq : '0;
      last        <= (pend_rest == '0);
    end
  end

endmodule

// File: design/capture_frequency_meter.sv
// top level of the four-channel input-capture frequency meter
// depends on cfm_pkg, cfm_front, cfm_queue, cfm_back (and through it cfm_div)
//
//  channel | signals                                          | moves
//  --------+--------------------------------------------------+-------------------------
//  in      | in_valid in_ready req_type channel capture_value | capture edge or tick
//  out     | out_valid out_ready out_channel event_kind       | one report per transaction
//          | frequency last                                   |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data           | one register write
//
// an input transaction is taken whenever the two-entry job queue has room
// in the back a timeout-only job is popped and goes straight to emitting its reports
// a measurement job goes through pop, multiply, add and check, then two passes
//   through the shared divider (clock by prescale, then by the period), then emits its
//   reports; a zero period or zero prescale skips both passes
// reset is synchronous; after it no clearing pass is needed, all state is in flops
// a stalled output holds its report; the front keeps taking transactions until the queue fills
module capture_frequency_meter #(
  parameter int CHANNELS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [cfm_pkg::CH_W-1:0]       channel,
  input  logic [cfm_pkg::CAP_W-1:0]      capture_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cfm_pkg::CH_W-1:0]       out_channel,
  output logic                           event_kind,
  output logic [cfm_pkg::DATA_W-1:0]     frequency,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfm_pkg::DATA_W-1:0]     cfg_data
);
  import cfm_pkg::*;

  // configuration registers; the user must write them only while the meter is idle, the block does not enforce it
  cfg_t cfg;

  // front to back job queue
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  job_t q_pop_job;
  logic q_full;
  logic q_empty;

  // register writes never stall
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_clock_hz <= RST_TIMER_CLOCK;
      cfg.prescale       <= RST_PRESCALE;
      cfg.reload_value   <= RST_RELOAD;
      cfg.success_skip   <= RST_SKIP;
      cfg.timeout_limit  <= RST_TIMEOUT;
      cfg.channel_enable <= RST_ENABLE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIMER_CLOCK: cfg.timer_clock_hz <= cfg_data;
        REG_PRESCALE:    cfg.prescale       <= cfg_data[PRESCALE_W-1:0];
        REG_RELOAD:      cfg.reload_value   <= cfg_data[CAP_W-1:0];
        REG_SKIP:        cfg.success_skip   <= cfg_data[SKIP_W-1:0];
        REG_TIMEOUT:     cfg.timeout_limit  <= cfg_data[CAP_W-1:0];
        REG_ENABLE:      cfg.channel_enable <= cfg_data[NUM_PORT_CH-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: edge pairing, lap and timeout counting, decimation, report mask
  cfm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .channel       (channel),
    .capture_value (capture_value),
    .q_full        (q_full),
    .push          (q_push),
    .push_job      (q_push_job)
  );

  // only transactions that cause at least one report enter the queue
  cfm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: period, frequency and reports in ascending channel order
  cfm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_job       (q_pop_job),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .event_kind  (event_kind),
    .frequency   (frequency),
    .last        (last)
  );

endmodule

// File: design/cfm_checker.sv
// port-level checks of the capture frequency meter, bound to the top level
// depends on cfm_pkg and capture_frequency_meter_assert.svh
`include "capture_frequency_meter_assert.svh"

module cfm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [cfm_pkg::CH_W-1:0]       out_channel,
  input logic                           event_kind,
  input logic [cfm_pkg::DATA_W-1:0]     frequency,
  input logic                           last,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);
  import cfm_pkg::*;

  // a timeout never carries a frequency
  `CFM_ASSERT_IMP(a_timeout_no_freq, out_valid && (event_kind == EVT_TIMEOUT), frequency == '0, "timeout report with nonzero frequency")

  // register writes are always taken at once
  `CFM_ASSERT_IMP(a_cfg_no_stall, cfg_valid, cfg_ready, "configuration write stalled")

  // a report waiting on the consumer stays put
  `CFM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_channel) && $stable(event_kind) && $stable(frequency) && $stable(last), "stalled report changed")

endmodule

bind capture_frequency_meter cfm_checker u_cfm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_channel (out_channel),
  .event_kind  (event_kind),
  .frequency   (frequency),
  .last        (last),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);
